FILE: design/iou_pkg.sv
`default_nettype none
package iou_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILTER,
        ST_RD,
        ST_RDWAIT,
        ST_GEOM,
        ST_DIV,
        ST_SCORE,
        ST_CMP,
        ST_WRITE,
        ST_OUT
    } state_t;

    localparam logic [1:0] CFG_CONF  = 2'd0;
    localparam logic [1:0] CFG_AREA  = 2'd1;
    localparam logic [1:0] CFG_MATCH = 2'd2;

    typedef struct packed {
        logic load;
        logic filter;
        logic geom;
        logic div_start;
        logic score;
        logic cmp;
        logic write;
        logic next_track;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic keep;
        logic more_tracks;
        logic div_done;
    } stat_t;

endpackage
`default_nettype wire

FILE: design/iou_ram.sv
`default_nettype none
module iou_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: design/iou_ctrl.sv
`default_nettype none
module iou_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    input  wire iou_pkg::stat_t stat,
    output iou_pkg::cmd_t      cmd
);
    import iou_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_FILTER;
            ST_FILTER: state_next = stat.keep ? ST_RD : ST_OUT;
            ST_RD:     state_next = stat.more_tracks ? ST_RDWAIT : ST_WRITE;
            ST_RDWAIT: state_next = ST_GEOM;
            ST_GEOM:   state_next = ST_DIV;
            ST_DIV:    if (stat.div_done) state_next = ST_SCORE;
            ST_SCORE:  state_next = ST_CMP;
            ST_CMP:    state_next = ST_RD;
            ST_WRITE:  state_next = ST_OUT;
            ST_OUT:    if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_stall       = (state_reg != ST_IDLE);
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:   cmd.load = in_valid;
            ST_FILTER: cmd.filter = 1'b1;
            ST_GEOM:   cmd.geom = 1'b1;
            ST_RDWAIT: cmd.div_start = 1'b0;
            ST_DIV:    cmd.div_start = 1'b0;
            ST_SCORE:  cmd.score = 1'b1;
            ST_CMP:
            begin
                cmd.cmp        = 1'b1;
                cmd.next_track = 1'b1;
            end
            ST_WRITE:  cmd.write = 1'b1;
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:   cmd = '0;
        endcase
        if (state_reg == ST_GEOM)
        begin
            cmd.div_start = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

FILE: design/iou_dp.sv
`default_nettype none
module iou_dp #(
    parameter int MAX_TRACKS = 16,
    parameter int COORD_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire iou_pkg::cmd_t         cmd,
    output iou_pkg::stat_t             stat,
    input  wire logic                  cfg_valid,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [23:0]           cfg_data,
    input  wire logic                  has_region,
    input  wire logic [COORD_BITS-1:0] box_x,
    input  wire logic [COORD_BITS-1:0] box_y,
    input  wire logic [COORD_BITS-1:0] box_w,
    input  wire logic [COORD_BITS-1:0] box_h,
    input  wire logic [15:0]           region_depth,
    input  wire logic [15:0]           region_confidence,
    input  wire logic                  last_in_frame,
    output logic                       kept,
    output logic [15:0]                track_id,
    output logic                       new_track,
    output logic                       store_overflow,
    output logic                       frame_done
);
    import iou_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int AB   = 2 * C;
    localparam int IB   = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CB   = $clog2(MAX_TRACKS + 1);
    localparam int ADB  = IB + 1;
    localparam int RAM_DEPTH = 2 ** ADB;
    localparam int BW   = 4 * C;
    localparam int UB   = AB + 1;
    localparam int NB   = AB + 17;
    localparam int DCW  = $clog2(NB + 1);

    logic [15:0] conf_th_reg, match_th_reg;
    logic [23:0] area_th_reg;

    logic [C-1:0]  x_reg, y_reg, w_reg, h_reg;
    logic [15:0]   d_reg, c_reg;
    logic          has_reg, last_reg, keep_reg;
    logic [AB-1:0] area_reg;

    logic          bank_reg;
    logic [CB-1:0] prev_cnt_reg, cur_cnt_reg, idx_reg;
    logic [15:0]   next_id_reg;
    logic [16:0]   best_reg;
    logic [15:0]   bid_reg;
    logic          found_reg;

    logic [BW-1:0] tb_rdata, tb_wdata;
    logic [31:0]   td_rdata, td_wdata;
    logic [ADB-1:0] raddr, waddr;
    logic          we;

    logic [UB-1:0] uni_reg;
    logic [16:0]   dq_reg;
    logic [15:0]   tid_reg;
    logic [NB-1:0] quo_reg;
    logic [UB:0]   rem_reg;
    logic [DCW-1:0] dcnt_reg;
    logic          div_busy_reg;
    logic [16:0]   score_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conf_th_reg  <= 16'd128;
            area_th_reg  <= 24'd100;
            match_th_reg <= 16'd32768;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CONF:  conf_th_reg  <= cfg_data[15:0];
                CFG_AREA:  area_th_reg  <= cfg_data;
                CFG_MATCH: match_th_reg <= cfg_data[15:0];
                default:   conf_th_reg  <= conf_th_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= box_x;
            y_reg    <= box_y;
            w_reg    <= box_w;
            h_reg    <= box_h;
            d_reg    <= region_depth;
            c_reg    <= region_confidence;
            has_reg  <= has_region;
            last_reg <= last_in_frame;
            area_reg <= box_w * box_h;
        end
    end

    // track buffers, one bank per frame
    assign raddr = {bank_reg, idx_reg[IB-1:0]};
    assign waddr = {~bank_reg, cur_cnt_reg[IB-1:0]};
    assign we    = cmd.write && keep_reg && (cur_cnt_reg < CB'(MAX_TRACKS));
    assign tb_wdata = {h_reg, w_reg, y_reg, x_reg};
    assign td_wdata = {(found_reg ? bid_reg : next_id_reg), d_reg};

    iou_ram #(.WIDTH(BW), .DEPTH(RAM_DEPTH)) u_box_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(tb_wdata),
        .raddr(raddr), .rdata(tb_rdata)
    );
    iou_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_depth_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(td_wdata),
        .raddr(raddr), .rdata(td_rdata)
    );

    // overlap geometry
    logic [C-1:0]  bx, by, bw, bh;
    logic [C:0]    ax_e, bx_e, ay_e, by_e, lo_x, hi_x, lo_y, hi_y, ow, oh;
    logic [15:0]   diff;
    logic [AB-1:0] barea, inter;
    logic [23:0]   diff256;
    logic [55:0]   dq_prod;
    logic [23:0]   dq_full;
    assign bx = tb_rdata[C-1:0];
    assign by = tb_rdata[2*C-1:C];
    assign bw = tb_rdata[3*C-1:2*C];
    assign bh = tb_rdata[4*C-1:3*C];
    always_comb
    begin
        ax_e = {1'b0, x_reg} + {1'b0, w_reg};
        bx_e = {1'b0, bx} + {1'b0, bw};
        ay_e = {1'b0, y_reg} + {1'b0, h_reg};
        by_e = {1'b0, by} + {1'b0, bh};
        lo_x = (x_reg > bx) ? {1'b0, x_reg} : {1'b0, bx};
        hi_x = (ax_e < bx_e) ? ax_e : bx_e;
        lo_y = (y_reg > by) ? {1'b0, y_reg} : {1'b0, by};
        hi_y = (ay_e < by_e) ? ay_e : by_e;
        ow   = (hi_x > lo_x) ? hi_x - lo_x : '0;
        oh   = (hi_y > lo_y) ? hi_y - lo_y : '0;
        inter = AB'(ow) * AB'(oh);
        barea = bw * bh;
        diff  = (d_reg > td_rdata[15:0]) ? d_reg - td_rdata[15:0]
                                         : td_rdata[15:0] - d_reg;
        diff256 = {diff, 8'd0};
        // floor(diff*256/5) by a rounded-up reciprocal, exact for 24-bit inputs
        dq_prod = 56'(diff256) * 56'd858993460;
        dq_full = 24'(dq_prod >> 32);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.geom)
        begin
            uni_reg   <= UB'({1'b0, area_reg} + {1'b0, barea} - {1'b0, inter});
            dq_reg    <= (dq_full > 24'd65536) ? 17'd65536 : dq_full[16:0];
            tid_reg   <= td_rdata[31:16];
        end
        else if (cmd.score)
        begin
            tid_reg <= tid_reg;
        end
        else if (cmd.filter)
        begin
            tid_reg <= next_id_reg;
        end
        else if (cmd.write && !found_reg)
        begin
            tid_reg <= next_id_reg;
        end
        else if (cmd.write)
        begin
            tid_reg <= bid_reg;
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            dcnt_reg     <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            dcnt_reg     <= DCW'(NB);
        end
        else if (div_busy_reg)
        begin
            dcnt_reg <= dcnt_reg - 1'b1;
            if (dcnt_reg == DCW'(1))
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    logic [UB:0] trial;
    assign trial = {rem_reg[UB-1:0], quo_reg[NB-1]};
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg <= {1'b0, inter, 16'd0};
            rem_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            if (trial >= {1'b0, uni_reg})
            begin
                rem_reg <= trial - {1'b0, uni_reg};
                quo_reg <= {quo_reg[NB-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[NB-2:0], 1'b0};
            end
        end
    end

    // score = (7*iou + 3*dterm) / 10 via reciprocal and correction
    logic [16:0] iou, dterm;
    logic [20:0] num;
    logic [41:0] prod;
    logic [20:0] q0, r0;
    assign iou   = (uni_reg == '0) ? 17'd0 : quo_reg[16:0];
    assign dterm = 17'd65536 - dq_reg;
    always_comb
    begin
        num  = 21'(21'(iou) * 21'd7 + 21'(dterm) * 21'd3);
        // rounded-down reciprocal: q0 is the quotient or one below it
        prod = 42'(num) * 42'd209715;
        q0   = 21'(prod >> 21);
        r0   = num - 21'(q0 * 21'd10);
    end
    always_ff @(posedge clk)
    begin
        if (cmd.score)
        begin
            if (uni_reg == '0)
                score_reg <= '0;
            else if (r0 >= 21'd10)
                score_reg <= 17'(q0 + 21'd1);
            else
                score_reg <= q0[16:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg     <= 1'b0;
            prev_cnt_reg <= '0;
            cur_cnt_reg  <= '0;
            next_id_reg  <= '0;
            keep_reg     <= 1'b0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            best_reg     <= '0;
            bid_reg      <= '0;
        end
        else
        begin
            if (cmd.filter)
            begin
                keep_reg  <= has_reg && (c_reg >= conf_th_reg)
                             && (32'(area_reg) >= 32'(area_th_reg));
                idx_reg   <= '0;
                found_reg <= 1'b0;
                best_reg  <= '0;
            end
            if (cmd.cmp)
            begin
                if (score_reg > best_reg && score_reg > {1'b0, match_th_reg})
                begin
                    best_reg  <= score_reg;
                    bid_reg   <= tid_reg;
                    found_reg <= 1'b1;
                end
            end
            if (cmd.next_track)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.write && keep_reg)
            begin
                if (!found_reg)
                    next_id_reg <= next_id_reg + 16'd1;
                if (cur_cnt_reg < CB'(MAX_TRACKS))
                    cur_cnt_reg <= cur_cnt_reg + 1'b1;
            end
            if (cmd.out_load && last_reg)
            begin
                bank_reg     <= ~bank_reg;
                prev_cnt_reg <= (cmd.write && keep_reg && cur_cnt_reg < CB'(MAX_TRACKS))
                                ? cur_cnt_reg + 1'b1 : cur_cnt_reg;
                cur_cnt_reg  <= '0;
            end
        end
    end

    assign stat.keep        = has_reg && (c_reg >= conf_th_reg)
                              && (32'(area_reg) >= 32'(area_th_reg));
    assign stat.more_tracks = (idx_reg < prev_cnt_reg);
    assign stat.div_done    = !div_busy_reg && !cmd.div_start;

    logic ovf_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            ovf_reg <= keep_reg && !(cur_cnt_reg < CB'(MAX_TRACKS));
        end
        if (cmd.out_load)
        begin
            kept           <= keep_reg;
            track_id       <= keep_reg ? tid_reg : 16'd0;
            new_track      <= keep_reg && !found_reg;
            store_overflow <= keep_reg && ovf_reg;
            frame_done     <= last_reg;
        end
    end
endmodule
`default_nettype wire

FILE: design/iou_region_track_associator_core.sv
`default_nettype none
// channel   direction  handshake          payload
// in        input      in_valid/in_stall  has_region, box_*, region_*, last_in_frame
// out       output     out_valid/out_stall kept, track_id, new_track, store_overflow,
//                                          frame_done
// cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
// kept region: filter, then per stored track read, wait, geometry, divide, score and
// compare, then write and result load; NB = 2*COORD_BITS+17 restoring iou divider steps
// (41 at COORD_BITS=12); dropped region or marker: filter, then result load
// next transfer is taken in the cycle after the result load
// reset clears counters and bank select and sets the default thresholds; no clearing pass
// a stalled result holds the output register; the next item then waits before its load
module iou_region_track_associator_core #(
    parameter int MAX_TRACKS = 16,
    parameter int COORD_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  has_region,
    input  wire logic [COORD_BITS-1:0] box_x,
    input  wire logic [COORD_BITS-1:0] box_y,
    input  wire logic [COORD_BITS-1:0] box_w,
    input  wire logic [COORD_BITS-1:0] box_h,
    input  wire logic [15:0]           region_depth,
    input  wire logic [15:0]           region_confidence,
    input  wire logic                  last_in_frame,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       kept,
    output logic [15:0]                track_id,
    output logic                       new_track,
    output logic                       store_overflow,
    output logic                       frame_done,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [23:0]           cfg_data
);
    import iou_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    iou_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
    );

    iou_dp #(.MAX_TRACKS(MAX_TRACKS), .COORD_BITS(COORD_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .has_region(has_region), .box_x(box_x), .box_y(box_y), .box_w(box_w),
        .box_h(box_h), .region_depth(region_depth),
        .region_confidence(region_confidence), .last_in_frame(last_in_frame),
        .kept(kept), .track_id(track_id), .new_track(new_track),
        .store_overflow(store_overflow), .frame_done(frame_done)
    );
endmodule
`default_nettype wire

FILE: design/iou_checker.sv
`default_nettype none
module iou_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic kept,
    input wire logic new_track,
    input wire logic store_overflow,
    input wire logic [15:0] track_id
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(track_id))
        else $error("held result changed");
    a_new: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_track |-> kept)
        else $error("new track without kept");
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && store_overflow |-> kept)
        else $error("overflow without kept");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transfer while busy");
endmodule

bind iou_region_track_associator_core iou_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .kept(kept),
    .new_track(new_track), .store_overflow(store_overflow), .track_id(track_id)
);
`default_nettype wire

FILE: verif/iou_region_track_associator_core_test.sv
`default_nettype none
module iou_region_track_associator_core_test;
    import iou_pkg::*;

    localparam int NTRK = 16;
    localparam int CB = 12;
    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic          has_region;
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic [CB-1:0] w;
        logic [CB-1:0] h;
        logic [15:0]   depth;
        logic [15:0]   conf;
        logic          last;
    } region_t;

    typedef struct packed {
        logic        kept;
        logic [15:0] id;
        logic        fresh;
        logic        ovf;
        logic        done;
    } assoc_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic has_region = 1'b0;
    logic [CB-1:0] box_x = '0, box_y = '0, box_w = '0, box_h = '0;
    logic [15:0] region_depth = '0, region_confidence = '0;
    logic last_in_frame = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic kept, new_track, store_overflow, frame_done;
    logic [15:0] track_id;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [23:0] cfg_data = '0;

    iou_region_track_associator_core #(.MAX_TRACKS(NTRK), .COORD_BITS(CB)) DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // tracker mirror
    logic [CB-1:0] trk_x[2*NTRK], trk_y[2*NTRK], trk_w[2*NTRK], trk_h[2*NTRK];
    logic [15:0] trk_depth[2*NTRK], trk_id[2*NTRK];
    logic bank = 1'b0;
    int prev_count = 0, cur_count = 0;
    logic [15:0] next_id = '0;
    logic [15:0] conf_thr = 16'd128;
    logic [23:0] area_min = 24'd100;
    logic [15:0] match_thr = 16'd32768;

    assoc_t pending_assoc[$];
    int errors = 0;
    int send_idle = 0, recv_idle = 0;
    int cycles = 0;

    function automatic logic [63:0] span_overlap(input logic [63:0] a0, al, b0, bl);
        logic [63:0] lo, hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a0 + al < b0 + bl) ? a0 + al : b0 + bl;
        return (hi > lo) ? hi - lo : 64'd0;
    endfunction

    function automatic logic [16:0] match_score(input region_t r, input int slot);
        logic [63:0] ow, oh, inter, uni, iou, diff, dq, dterm;
        ow = span_overlap(r.x, r.w, trk_x[slot], trk_w[slot]);
        oh = span_overlap(r.y, r.h, trk_y[slot], trk_h[slot]);
        inter = (ow != 0 && oh != 0) ? ow * oh : 64'd0;
        uni = 64'(r.w) * r.h + 64'(trk_w[slot]) * trk_h[slot] - inter;
        if (uni == 0)
            return '0;
        iou = (inter << 16) / uni;
        diff = (r.depth > trk_depth[slot]) ? r.depth - trk_depth[slot]
                                            : trk_depth[slot] - r.depth;
        dq = diff * 256 / 5;
        dterm = (dq >= 65536) ? 64'd0 : 65536 - dq;
        return 17'((7 * iou + 3 * dterm) / 10);
    endfunction

    task automatic associate(input region_t r, output assoc_t res);
        logic [16:0] best, s;
        logic found;
        logic [15:0] bid;
        int rb, wb;
        res = '0;
        best = '0;
        found = 1'b0;
        bid = '0;
        rb = bank * NTRK;
        wb = (!bank) * NTRK;
        if (r.has_region && r.conf >= conf_thr && 64'(r.w) * r.h >= area_min)
        begin
            for (int i = 0; i < prev_count; i++)
            begin
                s = match_score(r, rb + i);
                if (s > best && s > match_thr)
                begin
                    best = s;
                    bid = trk_id[rb + i];
                    found = 1'b1;
                end
            end
            res.kept = 1'b1;
            if (found)
                res.id = bid;
            else
            begin
                res.id = next_id;
                res.fresh = 1'b1;
                next_id = next_id + 16'd1;
            end
            if (cur_count < NTRK)
            begin
                trk_x[wb + cur_count] = r.x;
                trk_y[wb + cur_count] = r.y;
                trk_w[wb + cur_count] = r.w;
                trk_h[wb + cur_count] = r.h;
                trk_depth[wb + cur_count] = r.depth;
                trk_id[wb + cur_count] = res.id;
                cur_count++;
            end
            else
                res.ovf = 1'b1;
        end
        if (r.last)
        begin
            bank = !bank;
            prev_count = cur_count;
            cur_count = 0;
            res.done = 1'b1;
        end
    endtask

    // called at a rising edge; leaves valid high so the next item can follow directly
    task automatic send_region(input region_t r);
        assoc_t res;
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        has_region <= r.has_region;
        box_x <= r.x;
        box_y <= r.y;
        box_w <= r.w;
        box_h <= r.h;
        region_depth <= r.depth;
        region_confidence <= r.conf;
        last_in_frame <= r.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        associate(r, res);
        pending_assoc = {pending_assoc, res};
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_assoc.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_CONF:  conf_thr = val[15:0];
            CFG_AREA:  area_min = val;
            CFG_MATCH: match_thr = val[15:0];
            default:   ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic region_t make_region(input logic [CB-1:0] x, y, w, h,
                                            input logic [15:0] d, c, input logic last);
        region_t r;
        r = '{1'b1, x, y, w, h, d, c, last};
        return r;
    endfunction

    function automatic region_t frame_marker();
        region_t r;
        r = '0;
        r.last = 1'b1;
        return r;
    endfunction

    always @(posedge clk)
    begin
        assoc_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_assoc.size() == 0)
            begin
                $display("%0t: unexpected transfer kept=%b id=%0d", $time, kept, track_id);
                errors++;
            end
            else
            begin
                want = pending_assoc.pop_front();
                if (kept !== want.kept)
                begin
                    $display("%0t: kept exp %b got %b", $time, want.kept, kept);
                    errors++;
                end
                if (track_id !== want.id)
                begin
                    $display("%0t: track_id exp %0d got %0d", $time, want.id, track_id);
                    errors++;
                end
                if (new_track !== want.fresh)
                begin
                    $display("%0t: new_track exp %b got %b", $time, want.fresh, new_track);
                    errors++;
                end
                if (store_overflow !== want.ovf)
                begin
                    $display("%0t: store_overflow exp %b got %b", $time, want.ovf,
                             store_overflow);
                    errors++;
                end
                if (frame_done !== want.done)
                begin
                    $display("%0t: frame_done exp %b got %b", $time, want.done, frame_done);
                    errors++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    task automatic test_filter_and_match;
        send_region(make_region(12'd100, 12'd100, 12'd10, 12'd10, 16'h0200, 16'd128, 1'b0));
        send_region(make_region(12'd200, 12'd200, 12'd20, 12'd20, 16'h0200, 16'd127, 1'b0));
        send_region(make_region(12'd300, 12'd300, 12'd9, 12'd11, 16'h0200, 16'hffff, 1'b0));
        send_region(make_region(12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'hffff, 16'hffff,
                                1'b0));
        send_region(make_region(12'd0, 12'd0, 12'd4095, 12'd4095, 16'h0000, 16'h0100, 1'b0));
        send_region(frame_marker());
        // identical box and depth scores exactly 1.0
        send_region(make_region(12'd100, 12'd100, 12'd10, 12'd10, 16'h0200, 16'h0100, 1'b0));
        // same box but far depth
        send_region(make_region(12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'h0000, 16'h0100,
                                1'b0));
        send_region(make_region(12'd104, 12'd103, 12'd10, 12'd10, 16'h0205, 16'h0100, 1'b1));
        // empty marker without frame end
        send_region('0);
        send_region(frame_marker());
        send_region(frame_marker());
        drain();
    endtask

    task automatic test_buffer_overflow;
        for (int i = 0; i < NTRK + 3; i++)
            send_region(make_region(12'(i * 40), 12'd50, 12'd30, 12'd30, 16'(i * 64),
                                    16'h0100, i == NTRK + 2));
        // only the stored ones can match
        for (int i = 0; i < NTRK + 2; i++)
            send_region(make_region(12'(i * 40), 12'd50, 12'd30, 12'd30, 16'(i * 64),
                                    16'h0100, i == NTRK + 1));
        drain();
    endtask

    task automatic test_register_extremes;
        write_reg(CFG_CONF, 24'd0);
        write_reg(CFG_AREA, 24'd0);
        write_reg(CFG_MATCH, 24'd0);
        write_reg(CFG_SPARE, 24'hffffff);
        // zero-area boxes give an empty union, so they never match
        send_region(make_region(12'd10, 12'd10, 12'd0, 12'd0, 16'd0, 16'd0, 1'b1));
        send_region(make_region(12'd10, 12'd10, 12'd0, 12'd0, 16'd0, 16'd0, 1'b1));
        drain();
        write_reg(CFG_MATCH, 24'hffff);
        send_region(make_region(12'd7, 12'd9, 12'd50, 12'd60, 16'h1234, 16'd0, 1'b1));
        send_region(make_region(12'd7, 12'd9, 12'd50, 12'd60, 16'h1234, 16'd0, 1'b0));
        send_region(make_region(12'd8, 12'd9, 12'd50, 12'd60, 16'h1234, 16'd0, 1'b1));
        drain();
        write_reg(CFG_CONF, 24'hffff);
        write_reg(CFG_AREA, 24'hffffff);
        send_region(make_region(12'd0, 12'd0, 12'd4095, 12'd4095, 16'd5, 16'hffff, 1'b1));
        drain();
        write_reg(CFG_CONF, 24'd128);
        write_reg(CFG_AREA, 24'd100);
        write_reg(CFG_MATCH, 24'd32768);
    endtask

    function automatic region_t random_region(input logic last);
        region_t r;
        int slot;
        int pick;
        pick = $urandom_range(99);
        r = make_region(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                        16'($urandom), 16'($urandom), last);
        if (pick < 55 && prev_count > 0)
        begin
            // jitter a track of the previous frame
            slot = bank * NTRK + $urandom_range(prev_count - 1);
            r.x = trk_x[slot] + 12'($urandom_range(8)) - 12'd4;
            r.y = trk_y[slot] + 12'($urandom_range(8)) - 12'd4;
            r.w = trk_w[slot] + 12'($urandom_range(6)) - 12'd3;
            r.h = trk_h[slot] + 12'($urandom_range(6)) - 12'd3;
            r.depth = trk_depth[slot] + 16'($urandom_range(512)) - 16'd256;
            r.conf = 16'($urandom_range(conf_thr, 16'hffff));
        end
        else if (pick < 85)
        begin
            r.x = 12'($urandom_range(3000));
            r.y = 12'($urandom_range(3000));
            r.w = 12'($urandom_range(4, 120));
            r.h = 12'($urandom_range(4, 120));
            r.conf = ($urandom_range(9) == 0) ? 16'($urandom_range(conf_thr))
                                              : 16'($urandom_range(conf_thr, 16'hffff));
        end
        if ($urandom_range(29) == 0)
            r.has_region = 1'b0;
        return r;
    endfunction

    task automatic test_random_frames(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(NTRK, NTRK + 4)
                                           : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send_region(random_region(i == len - 1 && $urandom_range(1)));
            if (!last_in_frame)
                send_region(frame_marker());
            sent += len + 1;
            if ($urandom_range(19) == 0)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                wait (pending_assoc.size() == 0);
                @(posedge clk);
            end
        end
        drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle = 29;
        recv_idle = 53;
        test_filter_and_match();
        test_buffer_overflow();
        test_register_extremes();
        test_random_frames(170);
        send_idle = 53;
        recv_idle = 29;
        write_reg(CFG_CONF, 24'h0040);
        write_reg(CFG_AREA, 24'd400);
        write_reg(CFG_MATCH, 24'd20000);
        test_random_frames(170);
        send_idle = 0;
        recv_idle = 0;
        write_reg(CFG_CONF, 24'h0200);
        write_reg(CFG_AREA, 24'd16);
        write_reg(CFG_MATCH, 24'd50000);
        test_random_frames(170);
        repeat (100) @(posedge clk);
        if (errors == 0 && pending_assoc.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
design/iou_pkg.sv
design/iou_ram.sv
design/iou_ctrl.sv
design/iou_dp.sv
design/iou_region_track_associator_core.sv
design/iou_checker.sv
verif/iou_region_track_associator_core_test.sv
